@@ hdl/ddp_pkg.sv @@
// Shared types, constants and saturation helpers for the differential-drive
// wheel speed controller. No dependencies; every file but the checker imports this.

package ddp_pkg;

  // Setpoint limits and thresholds, Q.12
  localparam logic signed [15:0] LIN_LIMIT  = 16'sd4096;
  localparam logic signed [15:0] ANG_LIMIT  = 16'sd20480;
  localparam logic signed [23:0] SP_THRESH  = 24'sd41;

  // Drive offsets per wheel, whole drive units
  localparam logic [4:0] OFFSET_LEFT  = 5'd31;
  localparam logic [4:0] OFFSET_RIGHT = 5'd30;

  // Register reset values
  localparam logic [63:0] GAINS_RST      = 64'd0;
  localparam logic [15:0] TICK_SCALE_RST = 16'd0;
  localparam logic [15:0] INV_RADIUS_RST = 16'd5120;
  localparam logic [15:0] HALF_BASE_RST  = 16'd512;
  localparam logic [7:0]  MIN_DRIVE_RST  = 8'd0;
  localparam logic [7:0]  MAX_DRIVE_RST  = 8'd255;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAINS_LEFT  = 3'd0,
    CFG_GAINS_RIGHT = 3'd1,
    CFG_TICK_SCALE  = 3'd2,
    CFG_INV_RADIUS  = 3'd3,
    CFG_HALF_BASE   = 3'd4,
    CFG_MIN_DRIVE   = 3'd5,
    CFG_MAX_DRIVE   = 3'd6
  } cfg_index_e;

  // Top-level sequencing
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } top_state_e;

  // Per-wheel PID sequencer steps
  typedef enum logic [3:0] {
    LS_IDLE,
    LS_MUL_P,
    LS_MUL_I,
    LS_MUL_A,
    LS_MUL_D,
    LS_ADD_D,
    LS_SUM,
    LS_PRE,
    LS_DRIVE
  } lane_step_e;

  // Front end to wheel lane: error and setpoint of one tick
  typedef struct packed {
    logic               valid;
    logic signed [23:0] err;
    logic signed [23:0] sp;
  } ddp_req_t;

  // Wheel lane to merge stage
  typedef struct packed {
    logic              done;
    logic signed [8:0] drive;
  } ddp_rsp_t;

  // Saturate to 24-bit signed
  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    logic signed [23:0] r;
    if (x > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

  // Saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/ddp_front.sv @@
// Front end: wheel speed setpoints, measured wheel speeds and errors for
// both wheels in a four-stage pipeline. Depends on ddp_pkg.

module ddp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] lin_vel_i,
  input  logic signed [15:0] ang_vel_i,
  input  logic signed [15:0] enc_left_i,
  input  logic signed [15:0] enc_right_i,
  input  logic [15:0]        tick_scale_i,
  input  logic [15:0]        inv_radius_i,
  input  logic [15:0]        half_base_i,
  output ddp_pkg::ddp_req_t  req_left_o,
  output ddp_pkg::ddp_req_t  req_right_o
);
  import ddp_pkg::*;

  logic [3:0] vld_q;

  logic signed [15:0] lin_q, ang_q, enc_l_q, enc_r_q;
  logic signed [32:0] lin_prod_q, turn_prod_q;
  logic signed [33:0] meas_l_q, meas_r_q;
  logic signed [23:0] sp_l_q, sp_r_q, ml_q, mr_q;
  logic signed [23:0] sp_l2_q, sp_r2_q, err_l_q, err_r_q;

  logic signed [16:0] inv_s, half_s, ts_s, neg_l, neg_r;
  logic signed [33:0] diff_l, diff_r;

  assign inv_s  = $signed({1'b0, inv_radius_i});
  assign half_s = $signed({1'b0, half_base_i});
  assign ts_s   = $signed({1'b0, tick_scale_i});
  assign neg_l  = -17'(enc_l_q);
  assign neg_r  = -17'(enc_r_q);
  assign diff_l = 34'(lin_prod_q) - 34'(turn_prod_q);
  assign diff_r = 34'(lin_prod_q) + 34'(turn_prod_q);

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // Capture the beat, dropping over-range positive setpoints
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lin_q   <= (lin_vel_i > LIN_LIMIT) ? '0 : lin_vel_i;
      ang_q   <= (ang_vel_i > ANG_LIMIT) ? '0 : ang_vel_i;
      enc_l_q <= enc_left_i;
      enc_r_q <= enc_right_i;
    end
  end

  // Products of velocities and encoder deltas with their factors
  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      lin_prod_q  <= 33'(lin_q) * 33'(inv_s);
      turn_prod_q <= 33'(ang_q) * 33'(half_s);
      meas_l_q    <= 34'(neg_l) * 34'(ts_s);
      meas_r_q    <= 34'(neg_r) * 34'(ts_s);
    end
  end

  // Scale and saturate setpoints and measured speeds
  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      sp_l_q <= sat24(64'(diff_l >>> 8));
      sp_r_q <= sat24(64'(diff_r >>> 8));
      ml_q   <= sat24(64'(meas_l_q));
      mr_q   <= sat24(64'(meas_r_q));
    end
  end

  // Speed errors
  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      err_l_q <= sat24(64'(sp_l_q) - 64'(ml_q));
      err_r_q <= sat24(64'(sp_r_q) - 64'(mr_q));
      sp_l2_q <= sp_l_q;
      sp_r2_q <= sp_r_q;
    end
  end

  assign req_left_o.valid  = vld_q[3];
  assign req_left_o.err    = err_l_q;
  assign req_left_o.sp     = sp_l2_q;
  assign req_right_o.valid = vld_q[3];
  assign req_right_o.err   = err_r_q;
  assign req_right_o.sp    = sp_r2_q;

endmodule

@@ hdl/ddp_lane.sv @@
// One wheel lane: PID with back-calculation anti-windup on a single shared
// multiplier, then offset, drive clamp and dead band. Depends on ddp_pkg.

module ddp_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddp_pkg::ddp_req_t req_i,
  input  logic [63:0]       gains_i,
  input  logic [7:0]        min_drive_i,
  input  logic [7:0]        max_drive_i,
  input  logic [4:0]        offset_i,
  output ddp_pkg::ddp_rsp_t rsp_o
);
  import ddp_pkg::*;

  lane_step_e step_q, step_d;

  logic signed [23:0] err_q, sp_q, prev_error_q;
  logic signed [31:0] integral_q, prev_presum_q;
  logic signed [8:0]  prev_drive_q;
  logic               done_q;

  logic signed [31:0] p_q, i_q, d_q, sum_q, pre_q;
  logic signed [43:0] acc_q;
  logic signed [50:0] prod_q, prod_d;

  logic signed [16:0] mul_a;
  logic signed [33:0] mul_b, back;
  logic signed [42:0] term;
  logic signed [17:0] offs;

  logic signed [32:0] pre_x, mn_x, mx_x, pre_rnd;
  logic signed [20:0] mn_r, mx_r, raw;
  logic signed [8:0]  drive_d;

  assign back = 34'($signed({prev_drive_q, 12'b0})) - 34'(prev_presum_q);
  assign term = $signed(prod_q[50:8]);
  assign offs = (sp_q < SP_THRESH) ? -$signed({1'b0, offset_i, 12'b0})
                                   : $signed({1'b0, offset_i, 12'b0});

  // Step sequence and multiplier operand selection
  always_comb begin
    step_d = step_q;
    mul_a  = '0;
    mul_b  = '0;
    case (step_q)
      LS_IDLE: begin
        if (req_i.valid) step_d = LS_MUL_P;
      end
      LS_MUL_P: begin
        mul_a  = $signed({1'b0, gains_i[15:0]});
        mul_b  = 34'(err_q);
        step_d = LS_MUL_I;
      end
      LS_MUL_I: begin
        mul_a  = $signed({1'b0, gains_i[31:16]});
        mul_b  = 34'(err_q);
        step_d = LS_MUL_A;
      end
      LS_MUL_A: begin
        mul_a  = $signed({1'b0, gains_i[63:48]});
        mul_b  = back;
        step_d = LS_MUL_D;
      end
      LS_MUL_D: begin
        mul_a  = $signed({1'b0, gains_i[47:32]});
        mul_b  = 34'(err_q) - 34'(prev_error_q);
        step_d = LS_ADD_D;
      end
      LS_ADD_D: step_d = LS_SUM;
      LS_SUM:   step_d = LS_PRE;
      LS_PRE:   step_d = LS_DRIVE;
      LS_DRIVE: step_d = LS_IDLE;
      default:  step_d = LS_IDLE;
    endcase
    prod_d = 51'(mul_a) * 51'(mul_b);
  end

  // Clamp by setpoint sign, truncate toward zero, apply dead band
  always_comb begin
    pre_x   = 33'(pre_q);
    mn_x    = $signed({13'b0, min_drive_i, 12'b0});
    mx_x    = $signed({13'b0, max_drive_i, 12'b0});
    mn_r    = $signed({13'b0, min_drive_i});
    mx_r    = $signed({13'b0, max_drive_i});
    pre_rnd = pre_x + 33'sd4095;
    if (sp_q > 24'sd0 && pre_x < mn_x) begin
      raw = mn_r;
    end else if (sp_q > 24'sd0 && pre_x > mx_x) begin
      raw = mx_r;
    end else if (sp_q < 24'sd0 && pre_x > -mn_x) begin
      raw = -mn_r;
    end else if (sp_q < 24'sd0 && pre_x < -mx_x) begin
      raw = -mx_r;
    end else if (!pre_q[31]) begin
      raw = pre_x[32:12];
    end else begin
      raw = pre_rnd[32:12];
    end
    if (sp_q > -SP_THRESH && sp_q < SP_THRESH) raw = '0;
    if (raw > 21'sd255) begin
      drive_d = 9'sd255;
    end else if (raw < -21'sd256) begin
      drive_d = -9'sd256;
    end else begin
      drive_d = raw[8:0];
    end
  end

  // Sequencer and wheel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= LS_IDLE;
      done_q        <= 1'b0;
      prev_error_q  <= '0;
      integral_q    <= '0;
      prev_presum_q <= '0;
      prev_drive_q  <= '0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == LS_DRIVE);
      if (step_q == LS_DRIVE) begin
        prev_error_q  <= err_q;
        integral_q    <= i_q;
        prev_presum_q <= sum_q;
        prev_drive_q  <= drive_d;
      end
    end
  end

  // Datapath: register each product, then fold the registered product in
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (step_q)
      LS_IDLE: begin
        if (req_i.valid) begin
          err_q <= req_i.err;
          sp_q  <= req_i.sp;
        end
      end
      LS_MUL_I: p_q   <= sat32(64'(term));
      LS_MUL_A: acc_q <= 44'(integral_q) + 44'(term);
      LS_MUL_D: i_q   <= sat32(64'(acc_q) + 64'(term));
      LS_ADD_D: d_q   <= sat32(64'(term));
      LS_SUM:   sum_q <= sat32(64'(p_q) + 64'(i_q) + 64'(d_q));
      LS_PRE:   pre_q <= sat32(64'(sum_q) + 64'(offs));
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.drive = prev_drive_q;

endmodule

@@ hdl/diff_drive_pid_antiwindup_top.sv @@
// Top level of the differential-drive wheel speed controller: register
// file, front end, two wheel lanes and the output merge register.
// Depends on ddp_pkg, ddp_front and ddp_lane.

// One input beat per control tick yields one output beat carrying a signed
// drive for each wheel. Input closes when a beat is taken and opens again
// once the result is loaded into the output register, after the beat passes
// the four-stage front end and each wheel lane's sequencer, which pushes four
// PID products through a single multiplier and then adds, offsets and clamps
// over four more steps. A waiting result sits in the output register and does
// not block the next input beat; should a second result finish before the
// first is taken, the lanes hold it and input is stalled until the output
// register frees. Registers must be written by the user through the
// configuration channel only while no tick is in flight; the block itself
// does not enforce this, and the channel is always ready.

module diff_drive_pid_antiwindup_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: linear_velocity[15:0], angular_velocity[31:16],
  //               enc_delta_left[47:32], enc_delta_right[63:48]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // m_axis_tdata: drive_left[8:0], drive_right[17:9], zero [23:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import ddp_pkg::*;

  top_state_e state_q, state_d;

  logic [63:0] gains_left_q, gains_right_q;
  logic [15:0] tick_scale_q, inv_radius_q, half_base_q;
  logic [7:0]  min_drive_q, max_drive_q;

  logic        out_valid_q;
  logic [17:0] out_data_q;
  logic        out_free, load_out, accept;

  ddp_req_t req_left, req_right;
  ddp_rsp_t rsp_left, rsp_right;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign accept      = s_axis_tvalid && s_axis_tready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_left_q  <= GAINS_RST;
      gains_right_q <= GAINS_RST;
      tick_scale_q  <= TICK_SCALE_RST;
      inv_radius_q  <= INV_RADIUS_RST;
      half_base_q   <= HALF_BASE_RST;
      min_drive_q   <= MIN_DRIVE_RST;
      max_drive_q   <= MAX_DRIVE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GAINS_LEFT:  gains_left_q  <= cfg_data_i;
        CFG_GAINS_RIGHT: gains_right_q <= cfg_data_i;
        CFG_TICK_SCALE:  tick_scale_q  <= cfg_data_i[15:0];
        CFG_INV_RADIUS:  inv_radius_q  <= cfg_data_i[15:0];
        CFG_HALF_BASE:   half_base_q   <= cfg_data_i[15:0];
        CFG_MIN_DRIVE:   min_drive_q   <= cfg_data_i[7:0];
        CFG_MAX_DRIVE:   max_drive_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Tick sequencing
  always_comb begin
    state_d       = state_q;
    load_out      = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (rsp_left.done && rsp_right.done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d  = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  ddp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .lin_vel_i    ($signed(s_axis_tdata[15:0])),
    .ang_vel_i    ($signed(s_axis_tdata[31:16])),
    .enc_left_i   ($signed(s_axis_tdata[47:32])),
    .enc_right_i  ($signed(s_axis_tdata[63:48])),
    .tick_scale_i (tick_scale_q),
    .inv_radius_i (inv_radius_q),
    .half_base_i  (half_base_q),
    .req_left_o   (req_left),
    .req_right_o  (req_right)
  );

  ddp_lane u_lane_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_left),
    .gains_i     (gains_left_q),
    .min_drive_i (min_drive_q),
    .max_drive_i (max_drive_q),
    .offset_i    (OFFSET_LEFT),
    .rsp_o       (rsp_left)
  );

  ddp_lane u_lane_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_right),
    .gains_i     (gains_right_q),
    .min_drive_i (min_drive_q),
    .max_drive_i (max_drive_q),
    .offset_i    (OFFSET_RIGHT),
    .rsp_o       (rsp_right)
  );

  // Merge both lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_data_q <= {rsp_right.drive, rsp_left.drive};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

endmodule

@@ hdl/ddp_checker.sv @@
// Port-level checks for the wheel speed controller top, attached by bind.
// Depends only on the top level's ports.

module ddp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // Padding above the two drives stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'b0)
    else $error("result padding not zero");

  // Drives never reach the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8:0] != 9'h100 && m_axis_tdata[17:9] != 9'h100)
    else $error("drive out of range");

  // One tick at a time: input closes straight after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open while a tick is in flight");

endmodule

bind diff_drive_pid_antiwindup_top ddp_checker u_ddp_checker (.*);
